/* design/sinr_pkg.sv */
// Package for the signed integer n-th root block: widths, status codes and the
// microcode table (control word type, step names, program ROM).
// Depends on nothing; imported by signed_integer_nth_root and its testbench.
package sinr_pkg;

   localparam int DataWidth = 32;
   localparam int RootW     = DataWidth - 1;
   localparam int BitW      = $clog2(DataWidth - 1);
   localparam int IdxW      = 8;
   localparam int ProdW     = 2 * DataWidth;
   localparam int ReqBits   = DataWidth + IdxW;
   localparam int ReqDataW  = ((ReqBits + 7) / 8) * 8;
   localparam int RspBits   = 2 * RootW + 3;
   localparam int RspDataW  = ((RspBits + 7) / 8) * 8;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_INDEX_ZERO = 2'd1;
   localparam logic [1:0] STATUS_EVEN_NEG   = 2'd2;

   localparam int StepW = 4;

   localparam logic [StepW-1:0] S_WAIT  = 4'd0;
   localparam logic [StepW-1:0] S_BINIT = 4'd1;
   localparam logic [StepW-1:0] S_TRIAL = 4'd2;
   localparam logic [StepW-1:0] S_MUL   = 4'd3;
   localparam logic [StepW-1:0] S_CMP   = 4'd4;
   localparam logic [StepW-1:0] S_KEEP  = 4'd5;
   localparam logic [StepW-1:0] S_BNEXT = 4'd6;
   localparam logic [StepW-1:0] S_FINAL = 4'd7;
   localparam logic [StepW-1:0] S_FMUL  = 4'd8;
   localparam logic [StepW-1:0] S_FCMP  = 4'd9;
   localparam logic [StepW-1:0] S_EXACT = 4'd10;
   localparam logic [StepW-1:0] S_OUT   = 4'd11;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BIT_INIT,
      OP_TRIAL,
      OP_MUL,
      OP_ACC,
      OP_KEEP,
      OP_BIT_DEC,
      OP_FINAL,
      OP_EXACT,
      OP_EMIT
   } op_type;

   // Sequencing: NEXT advances; JUMP always goes to target.
   // WAIT_REQ holds until a request, then jumps on an error, else advances.
   // MUL_LOOP jumps to target on overflow, steps back one while multiplies
   // remain, else advances. BIT_LOOP jumps to target while bits remain.
   // WAIT_RSP holds until the result register is free, then jumps.
   typedef enum logic [2:0] {
      C_NEXT,
      C_JUMP,
      C_WAIT_REQ,
      C_MUL_LOOP,
      C_BIT_LOOP,
      C_WAIT_RSP
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [StepW-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [StepW-1:0] step);
      ucode_type w;
      w = '{op: OP_NONE, cond: C_JUMP, target: S_WAIT};
      unique case (step)
         S_WAIT:  w = '{op: OP_LOAD,     cond: C_WAIT_REQ, target: S_OUT};
         S_BINIT: w = '{op: OP_BIT_INIT, cond: C_NEXT,     target: S_WAIT};
         S_TRIAL: w = '{op: OP_TRIAL,    cond: C_NEXT,     target: S_WAIT};
         S_MUL:   w = '{op: OP_MUL,      cond: C_NEXT,     target: S_WAIT};
         S_CMP:   w = '{op: OP_ACC,      cond: C_MUL_LOOP, target: S_BNEXT};
         S_KEEP:  w = '{op: OP_KEEP,     cond: C_NEXT,     target: S_WAIT};
         S_BNEXT: w = '{op: OP_BIT_DEC,  cond: C_BIT_LOOP, target: S_TRIAL};
         S_FINAL: w = '{op: OP_FINAL,    cond: C_NEXT,     target: S_WAIT};
         S_FMUL:  w = '{op: OP_MUL,      cond: C_NEXT,     target: S_WAIT};
         S_FCMP:  w = '{op: OP_ACC,      cond: C_MUL_LOOP, target: S_EXACT};
         S_EXACT: w = '{op: OP_EXACT,    cond: C_NEXT,     target: S_WAIT};
         S_OUT:   w = '{op: OP_EMIT,     cond: C_WAIT_RSP, target: S_WAIT};
         default: w = '{op: OP_NONE,     cond: C_JUMP,     target: S_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* design/signed_integer_nth_root.sv */
// Signed integer n-th root: microcoded sequencer over a multiply/compare datapath.
// Depends on sinr_pkg (widths, status codes, microcode ROM).
//
// Usage:
//  - req channel (req_tvalid/req_tready/req_tdata) carries one transaction per
//    root: radicand and signed root index. req_tready is high only while the
//    sequencer sits in its wait step, so one item is worked on at a time.
//  - rsp channel returns one transaction per request: status in rsp_tuser,
//    brackets and flags in rsp_tdata. The result sits in an output register,
//    so the next request is taken while the previous result waits.
//  - The root is built one bit at a time, MSB first: each candidate is raised
//    to |index| by repeated multiplies on one 32x32 multiplier (two steps per
//    multiply), stopping as soon as the power passes |radicand|.
//  - An error goes straight from the wait step to the output step. Otherwise
//    each of the 31 bit trials, and the final check, runs multiplies until the
//    power passes |radicand|: at most |index| of them, and no more than 32 for
//    any candidate of 2 or more. The worst case is the largest |index|, where
//    the trial of candidate one runs all |index| multiplies; the multiplier
//    loop sets the run time.
//  - Reset (synchronous, active high) returns the sequencer to the wait step
//    and drops any pending result.
//  - When the receiver stalls, the result holds in rsp_tdata/rsp_tuser; one
//    more request may be taken and computed, then the sequencer holds in its
//    output step until the register frees.
module signed_integer_nth_root
   import sinr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // radicand, root_index
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // exact, root_low, root_high, negative,
                                            // reciprocal, zero pad
   output logic [1:0]          rsp_tuser    // status
);

   // sequencer
   logic [StepW-1:0]    pc_ff, pc_in;
   ucode_type           uc;

   // datapath
   logic [DataWidth-1:0] mag_ff, mag_in;
   logic [IdxW-1:0]      n_ff, n_in;
   logic                 neg_ff, neg_in;
   logic                 recip_ff, recip_in;
   logic [1:0]           status_ff, status_in;
   logic [RootW-1:0]     t_ff, t_in;
   logic [BitW-1:0]      bitpos_ff, bitpos_in;
   logic [DataWidth-1:0] cand_ff, cand_in;
   logic [DataWidth-1:0] acc_ff, acc_in;
   logic [ProdW-1:0]     prod_ff, prod_in;
   logic [IdxW-1:0]      cnt_ff, cnt_in;
   logic                 over_ff, over_in;
   logic                 exact_ff, exact_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   // request decode
   logic [DataWidth-1:0] req_rad;
   logic [IdxW-1:0]      req_idx;
   logic                 req_rad_neg;
   logic                 req_idx_neg;
   logic [DataWidth-1:0] req_mag;
   logic [IdxW-1:0]      req_n;
   logic [1:0]           req_status;
   logic                 req_fire;
   logic                 slot_free;
   logic                 gt;

   // result assembly
   logic                 sat;
   logic [RootW-1:0]     res_high;
   logic [RootW-1:0]     res_low;
   logic                 res_exact;
   logic [RspBits-1:0]   res_bits;

   assign uc         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == S_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign req_rad     = req_tdata[DataWidth-1:0];
   assign req_idx     = req_tdata[DataWidth +: IdxW];
   assign req_rad_neg = req_rad[DataWidth-1];
   assign req_idx_neg = req_idx[IdxW-1];
   // Negation wraps: the most negative radicand maps to 2^(DataWidth-1) and
   // index -128 maps to 128, both as unsigned magnitudes.
   assign req_mag     = req_rad_neg ? (~req_rad + 1'b1) : req_rad;
   assign req_n       = req_idx_neg ? (~req_idx + 1'b1) : req_idx;

   always_comb begin
      priority if (req_idx == '0) begin
         req_status = STATUS_INDEX_ZERO;
      end else if (req_rad_neg && !req_n[0]) begin
         req_status = STATUS_EVEN_NEG;
      end else begin
         req_status = STATUS_OK;
      end
   end

   // trial power has passed |radicand|
   assign gt = prod_ff > {{DataWidth{1'b0}}, mag_ff};

   // Result fields. A root of 2^(DataWidth-1) only comes from the most negative
   // radicand with an index of magnitude one; saturate both brackets and drop exact.
   assign sat       = cand_ff[DataWidth-1];
   assign res_high  = sat ? {RootW{1'b1}} : cand_ff[RootW-1:0];
   assign res_exact = exact_ff && !sat;
   assign res_low   = (sat || res_exact) ? res_high : res_high - 1'b1;

   always_comb begin
      if (status_ff == STATUS_OK) begin
         res_bits = {recip_ff, neg_ff, res_high, res_low, res_exact};
      end else begin
         res_bits = '0;
      end
   end

   // next step
   always_comb begin
      pc_in = pc_ff + 1'b1;
      unique case (uc.cond)
         C_NEXT: pc_in = pc_ff + 1'b1;
         C_JUMP: pc_in = uc.target;
         C_WAIT_REQ: begin
            priority if (!req_fire) begin
               pc_in = pc_ff;
            end else if (req_status != STATUS_OK) begin
               pc_in = uc.target;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         C_MUL_LOOP: begin
            // step back to the multiply while powers remain
            priority if (gt) begin
               pc_in = uc.target;
            end else if (cnt_ff != '0) begin
               pc_in = pc_ff - 1'b1;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         C_BIT_LOOP: pc_in = (bitpos_ff != '0) ? uc.target : pc_ff + 1'b1;
         C_WAIT_RSP: pc_in = slot_free ? uc.target : pc_ff;
         default:    pc_in = S_WAIT;
      endcase
   end

   // datapath actions
   always_comb begin
      mag_in    = mag_ff;
      n_in      = n_ff;
      neg_in    = neg_ff;
      recip_in  = recip_ff;
      status_in = status_ff;
      t_in      = t_ff;
      bitpos_in = bitpos_ff;
      cand_in   = cand_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      over_in   = over_ff;
      exact_in  = exact_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (uc.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            if (req_fire) begin
               mag_in    = req_mag;
               n_in      = req_n;
               neg_in    = req_rad_neg;
               recip_in  = req_idx_neg;
               status_in = req_status;
            end
         end
         OP_BIT_INIT: begin
            t_in      = '0;
            bitpos_in = BitW'(DataWidth - 2);
         end
         OP_TRIAL: begin
            cand_in = {1'b0, t_ff | (RootW'(1) << bitpos_ff)};
            acc_in  = DataWidth'(1);
            cnt_in  = n_ff;
            over_in = 1'b0;
         end
         OP_MUL: begin
            prod_in = {{DataWidth{1'b0}}, acc_ff} * {{DataWidth{1'b0}}, cand_ff};
            cnt_in  = cnt_ff - 1'b1;
         end
         OP_ACC: begin
            over_in = gt;
            if (!gt) begin
               acc_in = prod_ff[DataWidth-1:0];
            end
         end
         OP_KEEP: begin
            // candidate power stayed below |radicand|: keep the bit
            if (acc_ff < mag_ff) begin
               t_in = cand_ff[RootW-1:0];
            end
         end
         OP_BIT_DEC: begin
            if (bitpos_ff != '0) begin
               bitpos_in = bitpos_ff - 1'b1;
            end
         end
         OP_FINAL: begin
            // root is one above the largest t with t^n < |radicand|, or zero
            cand_in = (mag_ff == '0) ? '0 : {1'b0, t_ff} + 1'b1;
            acc_in  = DataWidth'(1);
            cnt_in  = n_ff;
            over_in = 1'b0;
         end
         OP_EXACT: begin
            exact_in = !over_ff && (acc_ff == mag_ff);
         end
         OP_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RspDataW'(res_bits);
               rsp_user_in  = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      recip_ff    <= recip_in;
      status_ff   <= status_in;
      t_ff        <= t_in;
      bitpos_ff   <= bitpos_in;
      cand_ff     <= cand_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      over_ff     <= over_in;
      exact_ff    <= exact_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* test/signed_integer_nth_root_tb.sv */
// Self-checking testbench for the signed integer n-th root block.
// Depends on sinr_pkg for widths and status codes, and on signed_integer_nth_root.
`timescale 1ns / 1ps

module signed_integer_nth_root_tb
   import sinr_pkg::*;
();

   // Cycles with no transaction on either side before the run is called hung.
   // The limit lies well above one item's run time and the long receiver hold-off.
   localparam int WatchdogLimit = 20000;
   localparam int HoldOffCycles = 3000;
   localparam int DrainCycles   = 2600;
   localparam int RandomItems   = 548;
   localparam int PrintLimit    = 40;
   localparam longint unsigned RadMax = 64'h7FFF_FFFF;

   // One expected result, fields in the order they leave the block.
   typedef struct {
      logic [1:0]       status;
      logic             exact;
      logic [RootW-1:0] root_low;
      logic [RootW-1:0] root_high;
      logic             negative;
      logic             reciprocal;
   } root_result_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;    // radicand, root_index
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;    // exact, root_low, root_high, negative,
                                      // reciprocal, zero pad
   logic [1:0]          rsp_tuser;    // status

   root_result_type pending_roots[$];
   int           mismatch_count;
   int           quiet_cycles;
   bit           steady;              // set: neither side idles
   bit           hold_off_req;        // set: receiver holds off for a long stretch

   signed_integer_nth_root dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // base^n, clipped to lim + 1 as soon as it passes lim.
   function automatic longint unsigned capped_power(input longint unsigned base,
                                                    input int unsigned n,
                                                    input longint unsigned lim);
      longint unsigned acc;
      acc = 1;
      if (base == 0) return 0;
      for (int unsigned i = 0; i < n; i++) begin
         if (acc > lim / base) return lim + 1;
         acc = acc * base;
      end
      if (acc > lim) return lim + 1;
      return acc;
   endfunction

   // Smallest natural r with r^|index| >= |radicand|, with brackets and flags.
   function automatic root_result_type predict_nth_root(input logic [DataWidth-1:0] rad,
                                                        input logic [IdxW-1:0] idx);
      root_result_type res;
      longint unsigned raw, mag, lo, hi, mid, r;
      int unsigned     n;
      logic            rad_neg, idx_neg, ex;
      res = '{STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b0};
      if (idx == '0) begin
         res.status = STATUS_INDEX_ZERO;
         return res;
      end
      idx_neg = idx[IdxW-1];
      rad_neg = rad[DataWidth-1];
      // minus 128 maps to magnitude 128, which counts as even
      n   = idx_neg ? 256 - int'(idx) : int'(idx);
      raw = longint'(rad);
      mag = rad_neg ? ((~raw) + 1) & 64'hFFFF_FFFF : raw;
      if (rad_neg && n[0] == 1'b0) begin
         res.status = STATUS_EVEN_NEG;
         return res;
      end
      lo = 0;
      hi = mag;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (capped_power(mid, n, mag) >= mag) hi = mid;
         else lo = mid + 1;
      end
      r  = lo;
      ex = (capped_power(r, n, mag) == mag);
      if (r > RadMax) begin
         // first root of the most negative radicand does not fit: saturate
         res.root_low  = RootW'(RadMax);
         res.root_high = RootW'(RadMax);
         ex = 1'b0;
      end else begin
         res.root_high = RootW'(r);
         res.root_low  = ex ? RootW'(r) : RootW'(r - 1);
      end
      res.exact      = ex;
      res.negative   = rad_neg && mag != 0;
      res.reciprocal = idx_neg;
      return res;
   endfunction

   // Idle length: mostly none or short, a few long; none during steady stretches.
   function automatic int idle_cycles();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      mismatch_count++;
      if (mismatch_count <= PrintLimit)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Offer one transaction, hold it until accepted, then queue its expectation.
   task automatic send_item(input logic [DataWidth-1:0] rad, input logic [IdxW-1:0] idx);
      root_result_type want;
      int           gap;
      want = predict_nth_root(rad, idx);
      gap  = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'({idx, rad});
      do @(posedge clock); while (!req_tready);
      pending_roots.push_back(want);
   endtask

   task automatic test_index_zero();
      send_item(32'd5, 8'd0);
      send_item(32'h8000_0000, 8'd0);
      send_item(32'hFFFF_FFFF, 8'd0);
   endtask

   task automatic test_even_root_of_negative();
      send_item(-32'sd4, 8'd2);
      send_item(-32'sd16, -8'sd2);
      send_item(-32'sd1, 8'h80);          // minus 128 is even
      send_item(32'h8000_0000, 8'd126);
   endtask

   task automatic test_zero_and_unit();
      send_item(32'd0, 8'd3);
      send_item(32'd0, -8'sd5);           // reciprocal flag still follows the index
      send_item(32'd0, 8'd2);
      send_item(32'd1, 8'd127);
      send_item(-32'sd1, 8'd1);
      send_item(32'd65536, 8'h80);
   endtask

   task automatic test_extreme_magnitudes();
      send_item(32'h7FFF_FFFF, 8'd1);
      send_item(32'h7FFF_FFFF, 8'd2);
      send_item(32'h7FFF_FFFF, 8'd127);
      send_item(32'h7FFF_FFFF, -8'sd127);
      send_item(32'h8000_0000, 8'd1);     // root too wide: brackets saturate
      send_item(32'h8000_0000, -8'sd1);
      send_item(32'h8000_0000, 8'd31);    // exact, root 2
      send_item(32'h8000_0001, 8'd3);
   endtask

   task automatic test_exact_and_bracketed();
      send_item(32'd144, 8'd2);
      send_item(32'd145, 8'd2);
      send_item(-32'sd27, 8'd3);
      send_item(-32'sd27, -8'sd3);
      send_item(32'd1000, 8'd127);        // 1 falls short, 2 overshoots
   endtask

   // Hold the receiver off while items keep coming, so the block fills and stalls.
   task automatic test_backpressure();
      steady       = 1'b1;
      hold_off_req = 1'b1;
      for (int i = 0; i < 8; i++) send_item($urandom, 8'($urandom_range(1, 4)));
      steady = 1'b0;
   endtask

   task automatic test_random_mix(input int count);
      logic [DataWidth-1:0] rad;
      logic [IdxW-1:0]      idx;
      longint unsigned      base, pwr;
      int                   n, pick;
      for (int i = 0; i < count; i++) begin
         steady = (i >= count / 3) && (i < count / 2);
         pick   = $urandom_range(0, 9);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: idx = 8'($urandom_range(1, 6));
            6, 7:             idx = 8'($urandom_range(7, 40));
            default:          idx = 8'($urandom);
         endcase
         if ($urandom_range(0, 9) < 4) idx = -idx;
         if (pick < 4) begin
            rad = $urandom;
         end else if (pick < 7) begin
            rad = DataWidth'($urandom_range(0, 2000));
            if ($urandom_range(0, 1)) rad = -rad;
         end else begin
            // perfect power, or one off it, for the exact and bracket edges
            n    = $urandom_range(2, 8);
            idx  = $urandom_range(0, 1) ? -8'(n) : 8'(n);
            base = $urandom_range(0, 46341);
            while (capped_power(base, n, RadMax) > RadMax) base = base >> 1;
            pwr = capped_power(base, n, RadMax);
            case ($urandom_range(0, 2))
               0: if (pwr > 0) pwr = pwr - 1;
               1: if (pwr < RadMax) pwr = pwr + 1;
               default: ;
            endcase
            rad = DataWidth'(pwr);
            if ($urandom_range(0, 1)) rad = -rad;
         end
         send_item(rad, idx);
      end
      steady = 1'b0;
   endtask

   // Receiver: random ready with gaps; a requested hold-off is counted here.
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles - 1) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_cycles()) @(posedge clock);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      root_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_roots.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata[RootW:1], 0);
         end else begin
            want = pending_roots.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[0] !== want.exact)
               report_mismatch("exact", rsp_tdata[0], want.exact);
            if (rsp_tdata[RootW:1] !== want.root_low)
               report_mismatch("root_low", rsp_tdata[RootW:1], want.root_low);
            if (rsp_tdata[2*RootW:RootW+1] !== want.root_high)
               report_mismatch("root_high", rsp_tdata[2*RootW:RootW+1], want.root_high);
            if (rsp_tdata[2*RootW+1] !== want.negative)
               report_mismatch("negative", rsp_tdata[2*RootW+1], want.negative);
            if (rsp_tdata[2*RootW+2] !== want.reciprocal)
               report_mismatch("reciprocal", rsp_tdata[2*RootW+2], want.reciprocal);
         end
      end
   end

   // Drop the run when no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("signed_integer_nth_root verification failed");
            $finish;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      steady         = 1'b0;
      hold_off_req   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_index_zero();
      test_even_root_of_negative();
      test_zero_and_unit();
      test_extreme_magnitudes();
      test_exact_and_bracketed();
      test_backpressure();
      test_random_mix(RandomItems);
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (pending_roots.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("signed_integer_nth_root verification clean");
      end else begin
         $display("signed_integer_nth_root verification failed");
      end
      $finish;
   end

endmodule
